>>> design/tkl_pkg.sv
// Shared types and constants for the top-k largest tracker.
package tkl_pkg;

   // Number of sorted cells in the row
   localparam int CAPACITY = 16;
   // Width of a count that can hold 0..CAPACITY
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   // Width of an index into the cell row
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Fixed field widths
   localparam int KEEP_W = 5;
   localparam int RANK_W = 4;
   localparam int TAG_W  = 32;
   localparam int SIZE_W = 64;

   // Reset value of keep_count
   localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

   // Request command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DUMP   = 1'b1;

   // Request as seen on the input ports
   typedef struct packed {
      logic              cmd;
      logic [TAG_W-1:0]  entry_tag;
      logic [SIZE_W-1:0] entry_size;
   } req_type;

   // Result as seen on the output ports
   typedef struct packed {
      logic              valid_res;
      logic [RANK_W-1:0] rank;
      logic [TAG_W-1:0]  held_tag;
      logic [SIZE_W-1:0] held_size;
      logic              last;
   } rsp_type;

   // Classified request held in the queue
   typedef struct packed {
      logic              is_dump;
      logic [TAG_W-1:0]  tag;
      logic [SIZE_W-1:0] size;
   } op_type;

   // Queue head offered to the back part
   typedef struct packed {
      logic   valid;
      op_type op;
   } qhead_type;

endpackage

>>> design/top_k_largest_tracker.sv
// Top level of the top-k largest tracker: queue ports, keep_count register and the two parts.
//
// Holds the largest (size, tag) pairs seen, up to keep_count of them, sorted by
// size with a new pair placed after held pairs of equal size. Both sides behave
// as queues: push a request while full is low, pop a result while empty is low.
// An insert enters the compare-and-shift cell row as it leaves the queue, so inserts go
// through at one per cycle while no dump is in progress and give no result. A dump holds
// the back part until it has emitted one result per held pair (one blank result if none
// are held), at one per cycle while results are popped, through the single result
// register; requests behind it wait in a four-deep request queue. Write keep_count only
// while the block is idle; a lowered value trims the table at the next insert.
module top_k_largest_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  tkl_pkg::req_type            req_data,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output tkl_pkg::rsp_type            rsp_data,
   input  logic                        csr_we,
   input  logic [tkl_pkg::KEEP_W-1:0]  csr_wdata
);

   logic [tkl_pkg::KEEP_W-1:0]  keep_count_ff;
   tkl_pkg::qhead_type          head;
   logic                        head_pop;

   // keep_count register
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff <= tkl_pkg::KEEP_RESET;
      end else if (csr_we) begin
         keep_count_ff <= csr_wdata;
      end
   end

   tkl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .head     (head),
      .head_pop (head_pop)
   );

   tkl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .keep_count (keep_count_ff),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

>>> design/tkl_front.sv
// Front part: accepts requests, classifies them and queues them for the back part.
module tkl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  tkl_pkg::req_type  req_data,
   output tkl_pkg::qhead_type head,
   input  logic              head_pop
);

   tkl_pkg::op_type                  queue_ff [tkl_pkg::QUEUE_DEPTH];
   logic [tkl_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tkl_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [tkl_pkg::QCNT_W-1:0]       count_ff, count_in;
   tkl_pkg::op_type                  op_new;
   logic                             do_push;
   logic                             do_pop;

   // Classify the incoming request
   always_comb begin
      op_new.is_dump = (req_data.cmd == tkl_pkg::CMD_DUMP);
      op_new.tag     = req_data.entry_tag;
      op_new.size    = req_data.entry_size;
   end

   assign req_full = (count_ff == tkl_pkg::QCNT_W'(tkl_pkg::QUEUE_DEPTH));
   assign do_push  = req_push && !req_full;
   assign do_pop   = head_pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.op    = queue_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == tkl_pkg::QPTR_W'(tkl_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == tkl_pkg::QPTR_W'(tkl_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= op_new;
      end
   end

endmodule

>>> design/tkl_back.sv
// Back part: sorted compare-and-shift cell row, dump sequencer and result register.
module tkl_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tkl_pkg::KEEP_W-1:0]  keep_count,
   input  tkl_pkg::qhead_type          head,
   output logic                        head_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output tkl_pkg::rsp_type            rsp_data
);

   typedef enum logic {
      ST_RUN,
      ST_DUMP
   } state_type;

   state_type                     state_ff, state_in;
   logic [tkl_pkg::CNT_W-1:0]     idx_ff, idx_in;
   logic [tkl_pkg::CNT_W-1:0]     held_ff, held_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   tkl_pkg::rsp_type              rsp_ff, rsp_in;

   logic [tkl_pkg::SIZE_W-1:0]    size_ff [tkl_pkg::CAPACITY];
   logic [tkl_pkg::TAG_W-1:0]     tag_ff  [tkl_pkg::CAPACITY];

   logic                          out_free;
   logic                          take;
   logic                          do_ins;
   logic [tkl_pkg::CNT_W-1:0]     keep_eff;
   logic [tkl_pkg::CNT_W-1:0]     keep_m1;
   logic [tkl_pkg::CNT_W-1:0]     live;
   logic [tkl_pkg::CAPACITY-1:0]  ge;
   logic                          ins_ok;
   logic [tkl_pkg::CNT_W-1:0]     rd_idx;
   logic                          rd_last;

   // Clamp keep_count to 1..CAPACITY
   always_comb begin
      if (keep_count == '0) begin
         keep_eff = tkl_pkg::CNT_W'(1);
      end else if (32'(keep_count) > tkl_pkg::CAPACITY) begin
         keep_eff = tkl_pkg::CNT_W'(tkl_pkg::CAPACITY);
      end else begin
         keep_eff = tkl_pkg::CNT_W'(keep_count);
      end
      keep_m1 = keep_eff - 1'b1;
      live    = (held_ff < keep_eff) ? held_ff : keep_eff;
   end

   // Each live cell compares its size against the new one; ge is a prefix mask
   always_comb begin
      for (int i = 0; i < tkl_pkg::CAPACITY; i++) begin
         ge[i] = (tkl_pkg::CNT_W'(i) < live) && (size_ff[i] >= head.op.size);
      end
      ins_ok = !ge[keep_m1[tkl_pkg::IDX_W-1:0]];
   end

   // Handshake with the queue and the result register
   assign out_free = !rsp_valid_ff || rsp_pop;
   assign take     = head.valid && (state_ff == ST_RUN) && (!head.op.is_dump || out_free);
   assign do_ins   = take && !head.op.is_dump;
   assign head_pop = take;

   // Dump read side
   assign rd_idx  = (state_ff == ST_DUMP) ? idx_ff : '0;
   assign rd_last = (rd_idx == held_ff - 1'b1);

   // Sequencer next state and result register
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      if (do_ins) begin
         held_in = (ins_ok && (live < keep_eff)) ? live + 1'b1 : live;
      end
      if ((take && head.op.is_dump) || ((state_ff == ST_DUMP) && out_free)) begin
         rsp_valid_in = 1'b1;
         if (held_ff == '0) begin
            // empty table: one blank result
            rsp_in.valid_res = 1'b0;
            rsp_in.rank      = '0;
            rsp_in.held_tag  = '0;
            rsp_in.held_size = '0;
            rsp_in.last      = 1'b1;
         end else begin
            rsp_in.valid_res = 1'b1;
            rsp_in.rank      = tkl_pkg::RANK_W'(rd_idx);
            rsp_in.held_tag  = tag_ff[rd_idx[tkl_pkg::IDX_W-1:0]];
            rsp_in.held_size = size_ff[rd_idx[tkl_pkg::IDX_W-1:0]];
            rsp_in.last      = rd_last;
            if (rd_last) begin
               state_in = ST_RUN;
            end else begin
               state_in = ST_DUMP;
               idx_in   = rd_idx + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         idx_ff       <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // Cell row: hold, take the new pair, or shift down from the cell above
   always_ff @(posedge clock) begin
      for (int i = 0; i < tkl_pkg::CAPACITY; i++) begin
         if (do_ins && ins_ok && (tkl_pkg::CNT_W'(i) < keep_eff) && !ge[i]) begin
            if (i == 0) begin
               size_ff[i] <= head.op.size;
               tag_ff[i]  <= head.op.tag;
            end else if (ge[(i == 0) ? 0 : i - 1]) begin
               size_ff[i] <= head.op.size;
               tag_ff[i]  <= head.op.tag;
            end else begin
               size_ff[i] <= size_ff[(i == 0) ? 0 : i - 1];
               tag_ff[i]  <= tag_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
